@@ design/i2d_pkg.sv @@
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared constants and types for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package i2d_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int MAX_CHARS  = 20;
    // One place of the text is reserved for the sign.
    localparam int NUM_DIGITS = MAX_CHARS - 1;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int POS_W      = $clog2(NUM_DIGITS);

    // Front queue depth; the front walks it with one-bit pointers.
    localparam int Q_DEPTH    = 2;

    // Double dabble: magnitude bits folded in per converter cycle.
    localparam int DD_BITS    = 4;
    localparam int DD_STEPS   = VALUE_W / DD_BITS;
    localparam int DD_CNT_W   = $clog2(DD_STEPS);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CHAR_W-1:0]         char_t;

    // Classified item: sign and unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

    // Converted item: sign and packed BCD digits, least significant lowest.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } digits_t;

endpackage

@@ design/i2d_value_if.sv @@
// ----------------------------------------------------------------------------
// i2d_value_if
// Valid/ready channel carrying one signed 64-bit value per beat.
// ----------------------------------------------------------------------------
interface i2d_value_if;
    import i2d_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

@@ design/i2d_char_if.sv @@
// ----------------------------------------------------------------------------
// i2d_char_if
// Valid/ready channel carrying one ASCII character and a last flag per beat.
// ----------------------------------------------------------------------------
interface i2d_char_if;
    import i2d_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);

endinterface

@@ design/i2d_front.sv @@
// ----------------------------------------------------------------------------
// i2d_front
// Accepts values, splits them into sign and magnitude, queues two items.
// ----------------------------------------------------------------------------
module i2d_front (
    input  logic             clk,
    input  logic             rst_n,
    i2d_value_if.sink        num,
    output logic             q_valid,
    output i2d_pkg::item_t   q_item,
    input  logic             q_pop
);
    import i2d_pkg::*;

    item_t       q_mem [Q_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        push;
    item_t       cls;

    // Two's complement negation as unsigned: the most negative value maps
    // to 2^63 with no overflow.
    always_comb
    begin
        cls.neg = num.value[VALUE_W-1];
        cls.mag = cls.neg ? (~num.value + VALUE_W'(1)) : num.value;
    end

    assign num.ready = (count_reg != 2'(Q_DEPTH));
    assign push      = num.valid && num.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/i2d_conv.sv @@
// ----------------------------------------------------------------------------
// i2d_conv
// Binary to BCD converter, double dabble, four magnitude bits per cycle.
// ----------------------------------------------------------------------------
module i2d_conv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  i2d_pkg::item_t     q_item,
    output logic               q_pop,
    output logic               done,
    output i2d_pkg::digits_t   result,
    input  logic               take
);
    import i2d_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DD_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [VALUE_W-1:0]  bin_reg,  bin_next;
    logic [BCD_W-1:0]    bcd_reg,  bcd_next;
    logic                neg_reg,  neg_next;
    logic [BCD_W-1:0]    bcd_step;

    // One double dabble bit: add 3 to every digit above 4, then shift in.
    function automatic logic [BCD_W-1:0] dd_bit(input logic [BCD_W-1:0] b,
                                                 input logic bin);
        logic [BCD_W-1:0]   adj;
        logic [DIGIT_W-1:0] d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = b[i*DIGIT_W +: DIGIT_W];
            adj[i*DIGIT_W +: DIGIT_W] = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
        end
        return {adj[BCD_W-2:0], bin};
    endfunction

    always_comb
    begin
        bcd_step = bcd_reg;
        for (int k = 0; k < DD_BITS; k++)
        begin
            bcd_step = dd_bit(bcd_step, bin_reg[VALUE_W-1-k]);
        end
    end

    assign q_pop  = q_valid && !busy_reg && !done_reg;
    assign done   = done_reg;
    assign result = '{neg: neg_reg, bcd: bcd_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = q_item.mag;
            bcd_next  = '0;
            neg_next  = q_item.neg;
        end
        else if (busy_reg)
        begin
            bcd_next = bcd_step;
            bin_next = {bin_reg[VALUE_W-DD_BITS-1:0], {DD_BITS{1'b0}}};
            cnt_next = cnt_reg + DD_CNT_W'(1);
            if (cnt_reg == DD_CNT_W'(DD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && take)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ design/i2d_emit.sv @@
// ----------------------------------------------------------------------------
// i2d_emit
// Walks the BCD digits from the leading one down, one character per beat.
// ----------------------------------------------------------------------------
module i2d_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               done,
    input  i2d_pkg::digits_t   result,
    output logic               take,
    i2d_char_if.source         text
);
    import i2d_pkg::*;

    logic               active_reg,   active_next;
    logic               neg_pend_reg, neg_pend_next;
    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic [BCD_W-1:0]   bcd_reg,      bcd_next;
    logic               out_valid_reg, out_valid_next;
    char_t              char_reg,     char_next;
    logic               last_reg,     last_next;
    logic [POS_W-1:0]   top;
    logic [DIGIT_W-1:0] digit;
    logic               advance;

    // Leading digit position; a zero magnitude keeps position 0.
    always_comb
    begin
        top = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (result.bcd[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                top = POS_W'(i);
            end
        end
    end

    assign take       = done && !active_reg;
    assign digit      = bcd_reg[pos_reg*DIGIT_W +: DIGIT_W];
    assign advance    = active_reg && (!out_valid_reg || text.ready);
    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    always_comb
    begin
        active_next    = active_reg;
        neg_pend_next  = neg_pend_reg;
        pos_next       = pos_reg;
        bcd_next       = bcd_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (take)
        begin
            active_next   = 1'b1;
            neg_pend_next = result.neg;
            pos_next      = top;
            bcd_next      = result.bcd;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            if (neg_pend_reg)
            begin
                char_next     = ASCII_MINUS;
                last_next     = 1'b0;
                neg_pend_next = 1'b0;
            end
            else
            begin
                char_next = ASCII_ZERO + CHAR_W'(digit);
                last_next = (pos_reg == '0);
                if (pos_reg == '0)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg - POS_W'(1);
                end
            end
        end
        else if (text.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            neg_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            neg_pend_reg  <= neg_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/signed_integer_to_decimal_text_core.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_decimal_text_core
// Formats a signed 64-bit integer as decimal ASCII text, one character a beat.
// ----------------------------------------------------------------------------
// Each beat on num carries one two's complement 64-bit value; the core
// answers with its decimal text on the text channel, most significant
// character first, one character per beat, with last set on the final one.
// Negative values start with '-', there are no leading zeros, zero prints
// as a single '0', and the most negative value prints in full (20 beats).
// An accepted value lands in a two-entry queue after its sign and magnitude
// are split off. The converter then runs a double dabble over the magnitude,
// four bits per cycle; the emitter then sends one character per cycle
// (1 to 20 beats) from a registered output while text is ready. The
// converter works on the next value while the emitter is still sending.
// No state is kept from one value to the next.
// ----------------------------------------------------------------------------
module signed_integer_to_decimal_text_core (
    input  logic        clk,
    input  logic        rst_n,
    i2d_value_if.sink   num,
    i2d_char_if.source  text
);
    import i2d_pkg::*;

    // Front to converter: queued sign and magnitude.
    logic     q_valid;
    logic     q_pop;
    item_t    q_item;

    // Converter to emitter: finished BCD digits held until taken.
    logic     conv_done;
    logic     emit_take;
    digits_t  conv_result;

    i2d_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .num     (num),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    i2d_conv u_conv (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .done    (conv_done),
        .result  (conv_result),
        .take    (emit_take)
    );

    i2d_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .done    (conv_done),
        .result  (conv_result),
        .take    (emit_take),
        .text    (text)
    );

endmodule
